[rtl/core/bdca_pkg.sv]
// Shared types and constants of the keypad debouncer.
`default_nettype none
package bdca_pkg;

    localparam int NBTN = 6;

    typedef logic [2:0] t_btn;

    localparam t_btn BTN_B1   = 3'd0;
    localparam t_btn BTN_B2   = 3'd1;
    localparam t_btn BTN_B3   = 3'd2;
    localparam t_btn BTN_B4   = 3'd3;
    localparam t_btn BTN_B5   = 3'd4;
    localparam t_btn BTN_LAST = 3'd5;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_MODE   = 3'd3;
    localparam logic [2:0] ACT_COMBO1 = 3'd6;
    localparam logic [2:0] ACT_COMBO2 = 3'd7;

    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_PRESS   = 3'd1;
    localparam logic [2:0] CAUSE_RELEASE = 3'd2;
    localparam logic [2:0] CAUSE_COMBO   = 3'd3;
    localparam logic [2:0] CAUSE_REPEAT  = 3'd4;

    localparam int ADDR_BITS = 5;

    localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [2:0] REG_FACE_DELAY   = 3'd1;
    localparam logic [2:0] REG_FACE_PERIOD  = 3'd2;
    localparam logic [2:0] REG_LEVEL_DELAY  = 3'd3;
    localparam logic [2:0] REG_LEVEL_PERIOD = 3'd4;

    localparam logic [15:0] RST_DEBOUNCE     = 16'd30;
    localparam logic [15:0] RST_FACE_DELAY   = 16'd500;
    localparam logic [15:0] RST_FACE_PERIOD  = 16'd150;
    localparam logic [15:0] RST_LEVEL_DELAY  = 16'd400;
    localparam logic [15:0] RST_LEVEL_PERIOD = 16'd100;

    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;
    localparam int QCNT_BITS = 3;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] face_delay;
        logic [15:0] face_period;
        logic [15:0] level_delay;
        logic [15:0] level_period;
    } t_cfg;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] cause;
        logic [5:0] held_mask;
        logic       last_of_tick;
    } t_res;

endpackage
`default_nettype wire

[rtl/core/bdca_tick_if.sv]
// Input channel: one tick beat with time and raw button levels.
`default_nettype none
interface bdca_tick_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [5:0]  raw_levels;

    modport source(output valid, now_ms, raw_levels, input ready);
    modport sink(input valid, now_ms, raw_levels, output ready);
endinterface
`default_nettype wire

[rtl/core/bdca_res_if.sv]
// Output channel: one result beat per action, or one empty beat for a tick without any.
`default_nettype none
interface bdca_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [2:0] cause;
    logic [5:0] held_mask;
    logic       last_of_tick;

    modport source(output valid, action, cause, held_mask, last_of_tick, input ready);
    modport sink(input valid, action, cause, held_mask, last_of_tick, output ready);
endinterface
`default_nettype wire

[rtl/core/button_debounce_combo_autorepeat.sv]
// Top level: six-button debouncer with combo and auto-repeat, APB settings.
//
//   channel   dir  beat
//   i_tick    in   now_ms[31:0], raw_levels[5:0]
//   o_res     out  action[2:0], cause[2:0], held_mask[5:0], last_of_tick
//   apb       in   settings registers at byte address 4*index
//
// From acceptance until ready again, a tick walks the front through the six
// buttons three times (debounce, emit, repeat), the debounce and repeat walks
// sharing one pair of elapsed-time compares, then a flush state closes it.
// Pushes wait while the 4-entry result queue is full; the output register
// lets the consumer stall independently. Synchronous active-low reset:
// all buttons released, all stored button times zero, settings at their defaults.
`default_nettype none
module button_debounce_combo_autorepeat #(
    parameter int TIME_BITS = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    bdca_tick_if.sink                        i_tick,
    bdca_res_if.source                       o_res,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [bdca_pkg::ADDR_BITS-1:0]   paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import bdca_pkg::*;

    t_cfg       r_cfg, n_cfg;
    logic [2:0] w_reg_idx;
    logic       w_push_vld, w_push_rdy, w_pop_vld, w_pop_rdy, w_out_vld;
    t_res       w_push, w_pop, w_out;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_BITS-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (w_reg_idx)
                REG_DEBOUNCE:     n_cfg.debounce_ms  = pwdata[15:0];
                REG_FACE_DELAY:   n_cfg.face_delay   = pwdata[15:0];
                REG_FACE_PERIOD:  n_cfg.face_period  = pwdata[15:0];
                REG_LEVEL_DELAY:  n_cfg.level_delay  = pwdata[15:0];
                REG_LEVEL_PERIOD: n_cfg.level_period = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_DEBOUNCE:     prdata = {16'd0, r_cfg.debounce_ms};
            REG_FACE_DELAY:   prdata = {16'd0, r_cfg.face_delay};
            REG_FACE_PERIOD:  prdata = {16'd0, r_cfg.face_period};
            REG_LEVEL_DELAY:  prdata = {16'd0, r_cfg.level_delay};
            REG_LEVEL_PERIOD: prdata = {16'd0, r_cfg.level_period};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms  <= RST_DEBOUNCE;
            r_cfg.face_delay   <= RST_FACE_DELAY;
            r_cfg.face_period  <= RST_FACE_PERIOD;
            r_cfg.level_delay  <= RST_LEVEL_DELAY;
            r_cfg.level_period <= RST_LEVEL_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    bdca_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_tick_vld (i_tick.valid),
        .o_tick_rdy (i_tick.ready),
        .i_now_ms   (i_tick.now_ms),
        .i_raw      (i_tick.raw_levels),
        .o_push_vld (w_push_vld),
        .i_push_rdy (w_push_rdy),
        .o_push     (w_push)
    );

    bdca_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (w_push_vld),
        .o_push_rdy (w_push_rdy),
        .i_push     (w_push),
        .o_pop_vld  (w_pop_vld),
        .i_pop_rdy  (w_pop_rdy),
        .o_pop      (w_pop)
    );

    bdca_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pop_vld (w_pop_vld),
        .o_pop_rdy (w_pop_rdy),
        .i_pop     (w_pop),
        .o_out_vld (w_out_vld),
        .i_out_rdy (o_res.ready),
        .o_out     (w_out)
    );

    assign o_res.valid        = w_out_vld;
    assign o_res.action       = w_out.action;
    assign o_res.cause        = w_out.cause;
    assign o_res.held_mask    = w_out.held_mask;
    assign o_res.last_of_tick = w_out.last_of_tick;

    // a tick keeps the front busy: ready drops once a tick is accepted
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_tick.valid && i_tick.ready |=> !i_tick.ready)
        else $error("front ready right after accepting a tick");

    a_quiet_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.cause == CAUSE_NONE |->
            o_res.action == ACT_NONE && o_res.last_of_tick)
        else $error("empty result not a lone last beat");

    a_repeat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.cause == CAUSE_REPEAT |->
            o_res.held_mask[o_res.action - 3'd1])
        else $error("repeat of a button that is not held");

endmodule
`default_nettype wire

[rtl/core/bdca_front.sv]
// Front sequencer: debounces buttons, classifies edges and repeats, pushes results.
`default_nettype none
module bdca_front #(
    parameter int TIME_BITS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  bdca_pkg::t_cfg      i_cfg,
    input  wire                 i_tick_vld,
    output logic                o_tick_rdy,
    input  wire  [31:0]         i_now_ms,
    input  wire  [5:0]          i_raw,
    output logic                o_push_vld,
    input  wire                 i_push_rdy,
    output bdca_pkg::t_res      o_push
);
    import bdca_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DEB   = 5'b00010,
        S_EMIT  = 5'b00100,
        S_RPT   = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    typedef logic [TIME_BITS-1:0] t_time;

    t_state     r_state, n_state;
    t_btn       r_step, n_step;
    t_time      r_now, n_now;
    logic [5:0] r_raw, n_raw;
    logic [5:0] r_raw_seen, n_raw_seen;
    logic [5:0] r_held, n_held;
    logic [5:0] r_cons, n_cons;
    t_time      r_chg [NBTN];
    t_time      n_chg [NBTN];
    t_time      r_prs [NBTN];
    t_time      n_prs [NBTN];
    t_time      r_rpt [NBTN];
    t_time      n_rpt [NBTN];
    logic [5:0] r_ev_vld, n_ev_vld;
    logic [2:0] r_ev_act [NBTN];
    logic [2:0] n_ev_act [NBTN];
    logic [2:0] r_ev_cause [NBTN];
    logic [2:0] n_ev_cause [NBTN];
    logic       r_pend_vld, n_pend_vld;
    logic [2:0] r_pend_act, n_pend_act;
    logic [2:0] r_pend_cause, n_pend_cause;

    logic       w_r, w_chg, w_face, w_level;
    t_time      w_then_a, w_thr_a, w_thr_b;
    logic       w_pass_a, w_pass_b;
    logic       w_flip, w_combo, w_press, w_mode;
    logic [2:0] w_dact, w_dcause;
    logic       w_rpt_ev, w_ev, w_stall;
    logic [2:0] w_ev_act, w_ev_cause;

    assign w_r     = r_raw[r_step];
    assign w_chg   = w_r != r_raw_seen[r_step];
    assign w_face  = (r_step == BTN_B1) || (r_step == BTN_B2);
    assign w_level = (r_step == BTN_B4) || (r_step == BTN_B5);

    // shared pair of wrapped elapsed-time compares
    assign w_then_a = (r_state == S_DEB) ? (w_chg ? r_now : r_chg[r_step]) : r_prs[r_step];
    assign w_thr_a  = (r_state == S_DEB) ? TIME_BITS'(i_cfg.debounce_ms)
                    : w_face ? TIME_BITS'(i_cfg.face_delay) : TIME_BITS'(i_cfg.level_delay);
    assign w_thr_b  = w_face ? TIME_BITS'(i_cfg.face_period) : TIME_BITS'(i_cfg.level_period);
    assign w_pass_a = t_time'(r_now - w_then_a) >= w_thr_a;
    assign w_pass_b = t_time'(r_now - r_rpt[r_step]) >= w_thr_b;

    assign w_flip   = w_pass_a && (w_r != r_held[r_step]);
    assign w_combo  = w_flip && w_r && w_face && r_held[BTN_B3];
    assign w_press  = w_flip && w_r && !w_combo && (w_face || w_level);
    assign w_mode   = w_flip && !w_r && (r_step == BTN_B3) && !r_cons[BTN_B3];
    assign w_dact   = w_combo ? ((r_step == BTN_B1) ? ACT_COMBO1 : ACT_COMBO2)
                    : w_mode ? ACT_MODE : r_step + 3'd1;
    assign w_dcause = w_combo ? CAUSE_COMBO : w_mode ? CAUSE_RELEASE : CAUSE_PRESS;

    assign w_rpt_ev = r_held[r_step] && !r_cons[r_step] && (w_face || w_level)
                   && !(w_face && r_held[BTN_B3]) && w_pass_a && w_pass_b;

    assign w_ev       = (r_state == S_EMIT) ? r_ev_vld[r_step]
                      : (r_state == S_RPT) ? w_rpt_ev : 1'b0;
    assign w_ev_act   = (r_state == S_EMIT) ? r_ev_act[r_step] : r_step + 3'd1;
    assign w_ev_cause = (r_state == S_EMIT) ? r_ev_cause[r_step] : CAUSE_REPEAT;

    // a new event pushes the previous one, which is then known not to be last
    assign w_stall = w_ev && r_pend_vld && !i_push_rdy;

    assign o_tick_rdy = r_state == S_IDLE;
    assign o_push_vld = (r_state == S_FLUSH) || (w_ev && r_pend_vld);

    always_comb begin
        o_push.held_mask = r_held;
        if (r_state == S_FLUSH) begin
            o_push.action       = r_pend_vld ? r_pend_act : ACT_NONE;
            o_push.cause        = r_pend_vld ? r_pend_cause : CAUSE_NONE;
            o_push.last_of_tick = 1'b1;
        end else begin
            o_push.action       = r_pend_act;
            o_push.cause        = r_pend_cause;
            o_push.last_of_tick = 1'b0;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_now        = r_now;
        n_raw        = r_raw;
        n_raw_seen   = r_raw_seen;
        n_held       = r_held;
        n_cons       = r_cons;
        n_chg        = r_chg;
        n_prs        = r_prs;
        n_rpt        = r_rpt;
        n_ev_vld     = r_ev_vld;
        n_ev_act     = r_ev_act;
        n_ev_cause   = r_ev_cause;
        n_pend_vld   = r_pend_vld;
        n_pend_act   = r_pend_act;
        n_pend_cause = r_pend_cause;
        case (r_state)
            S_IDLE: begin
                if (i_tick_vld) begin
                    n_now   = TIME_BITS'(i_now_ms);
                    n_raw   = i_raw;
                    n_step  = '0;
                    n_state = S_DEB;
                end
            end
            S_DEB: begin
                n_raw_seen[r_step] = w_r;
                if (w_chg) begin
                    n_chg[r_step] = r_now;
                end
                if (w_flip) begin
                    n_held[r_step] = w_r;
                    n_cons[r_step] = 1'b0;
                    if (w_r) begin
                        n_prs[r_step] = r_now;
                        n_rpt[r_step] = r_now;
                    end
                    if (w_combo) begin
                        n_cons[r_step] = 1'b1;
                        n_cons[BTN_B3] = 1'b1;
                    end
                end
                n_ev_vld[r_step]   = w_combo || w_press || w_mode;
                n_ev_act[r_step]   = w_dact;
                n_ev_cause[r_step] = w_dcause;
                if (r_step == BTN_LAST) begin
                    n_step  = '0;
                    n_state = S_EMIT;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_EMIT, S_RPT: begin
                if (!w_stall) begin
                    if (w_ev) begin
                        n_pend_vld   = 1'b1;
                        n_pend_act   = w_ev_act;
                        n_pend_cause = w_ev_cause;
                        if (r_state == S_RPT) begin
                            n_rpt[r_step] = r_now;
                        end
                    end
                    if (r_step == BTN_LAST) begin
                        n_step  = '0;
                        n_state = (r_state == S_EMIT) ? S_RPT : S_FLUSH;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            S_FLUSH: begin
                if (i_push_rdy) begin
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_raw_seen <= '0;
            r_held     <= '0;
            r_cons     <= '0;
            r_ev_vld   <= '0;
            r_pend_vld <= 1'b0;
            for (int i = 0; i < NBTN; i++) begin
                r_chg[i] <= '0;
                r_prs[i] <= '0;
                r_rpt[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_raw_seen <= n_raw_seen;
            r_held     <= n_held;
            r_cons     <= n_cons;
            r_ev_vld   <= n_ev_vld;
            r_pend_vld <= n_pend_vld;
            r_chg      <= n_chg;
            r_prs      <= n_prs;
            r_rpt      <= n_rpt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now        <= n_now;
        r_raw        <= n_raw;
        r_ev_act     <= n_ev_act;
        r_ev_cause   <= n_ev_cause;
        r_pend_act   <= n_pend_act;
        r_pend_cause <= n_pend_cause;
    end

endmodule
`default_nettype wire

[rtl/core/bdca_fifo.sv]
// Result queue between the front sequencer and the output stage.
`default_nettype none
module bdca_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push_vld,
    output logic            o_push_rdy,
    input  bdca_pkg::t_res  i_push,
    output logic            o_pop_vld,
    input  wire             i_pop_rdy,
    output bdca_pkg::t_res  o_pop
);
    import bdca_pkg::*;

    t_res                 r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wptr, n_wptr;
    logic [QPTR_BITS-1:0] r_rptr, n_rptr;
    logic [QCNT_BITS-1:0] r_cnt, n_cnt;
    logic                 w_push, w_pop;

    assign o_push_rdy = r_cnt != QCNT_BITS'(QDEPTH);
    assign o_pop_vld  = r_cnt != '0;
    assign o_pop      = r_mem[r_rptr];
    assign w_push     = i_push_vld && o_push_rdy;
    assign w_pop      = o_pop_vld && i_pop_rdy;

    always_comb begin
        n_wptr = w_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = w_pop ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push;
        end
    end

endmodule
`default_nettype wire

[rtl/core/bdca_back.sv]
// Output stage: registers one result beat toward the consumer.
`default_nettype none
module bdca_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_pop_vld,
    output logic            o_pop_rdy,
    input  bdca_pkg::t_res  i_pop,
    output logic            o_out_vld,
    input  wire             i_out_rdy,
    output bdca_pkg::t_res  o_out
);
    import bdca_pkg::*;

    logic r_vld, n_vld;
    t_res r_res, n_res;

    assign o_pop_rdy = !r_vld || i_out_rdy;
    assign o_out_vld = r_vld;
    assign o_out     = r_res;

    always_comb begin
        n_vld = r_vld;
        n_res = r_res;
        if (o_pop_rdy) begin
            n_vld = i_pop_vld;
            if (i_pop_vld) begin
                n_res = i_pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule
`default_nettype wire

[dv/button_debounce_combo_autorepeat_tb.sv]
// Testbench for the keypad debouncer: directed tick table, then random ticks checked by a predictor.
`timescale 1ns / 100ps
module button_debounce_combo_autorepeat_tb;
    import bdca_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int NREG          = 5;
    localparam int MAX_REG       = (1 << ADDR_BITS) / 4 - 1;
    localparam int REG_STRIDE    = 4;

    localparam logic [2:0] ACT_B1 = 3'd1;
    localparam logic [2:0] ACT_B2 = 3'd2;
    localparam logic [2:0] ACT_B4 = 3'd4;
    localparam logic [2:0] ACT_B5 = 3'd5;

    localparam t_res NO_RES = '0;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [5:0]  raw;
        logic        cfg_zero;
        logic        typed;
        t_res        exp_res;
    } t_dir_row;

    localparam int N_DIR = 29;
    localparam t_dir_row DIR_TBL [N_DIR] = '{
        '{32'd0,    6'h00, 1'b0, 1'b1, '{ACT_NONE, CAUSE_NONE, 6'h00, 1'b1}},
        '{32'd10,   6'h01, 1'b0, 1'b0, NO_RES},
        '{32'd40,   6'h01, 1'b0, 1'b1, '{ACT_B1, CAUSE_PRESS, 6'h01, 1'b1}},
        '{32'd540,  6'h01, 1'b0, 1'b0, NO_RES},
        '{32'd700,  6'h05, 1'b0, 1'b0, NO_RES},
        '{32'd730,  6'h05, 1'b0, 1'b0, NO_RES},
        '{32'd740,  6'h00, 1'b0, 1'b0, NO_RES},
        '{32'd770,  6'h00, 1'b0, 1'b1, '{ACT_MODE, CAUSE_RELEASE, 6'h00, 1'b1}},
        '{32'd800,  6'h04, 1'b0, 1'b0, NO_RES},
        '{32'd830,  6'h06, 1'b0, 1'b0, NO_RES},
        '{32'd860,  6'h06, 1'b0, 1'b1, '{ACT_COMBO2, CAUSE_COMBO, 6'h06, 1'b1}},
        '{32'd870,  6'h00, 1'b0, 1'b0, NO_RES},
        '{32'd900,  6'h00, 1'b0, 1'b1, '{ACT_NONE, CAUSE_NONE, 6'h00, 1'b1}},
        '{32'd1000, 6'h38, 1'b0, 1'b0, NO_RES},
        '{32'd1030, 6'h38, 1'b0, 1'b0, NO_RES},
        '{32'd1430, 6'h38, 1'b0, 1'b0, NO_RES},
        '{32'd1440, 6'h3F, 1'b0, 1'b0, NO_RES},
        '{32'd1470, 6'h3F, 1'b0, 1'b0, NO_RES},
        '{32'hFFFF_FFF0, 6'h3F, 1'b0, 1'b0, NO_RES},
        '{32'h0000_0010, 6'h00, 1'b0, 1'b0, NO_RES},
        '{32'h0000_002E, 6'h00, 1'b0, 1'b0, NO_RES},
        '{32'hFFFF_FFFF, 6'h00, 1'b0, 1'b1, '{ACT_NONE, CAUSE_NONE, 6'h00, 1'b1}},
        '{32'd5000, 6'h00, 1'b1, 1'b1, '{ACT_NONE, CAUSE_NONE, 6'h00, 1'b1}},
        '{32'd5001, 6'h1B, 1'b0, 1'b0, NO_RES},
        '{32'd5003, 6'h1F, 1'b0, 1'b0, NO_RES},
        '{32'd5004, 6'h00, 1'b0, 1'b0, NO_RES},
        '{32'd5005, 6'h04, 1'b0, 1'b0, NO_RES},
        '{32'd5006, 6'h05, 1'b0, 1'b0, NO_RES},
        '{32'd5007, 6'h20, 1'b0, 1'b1, '{ACT_NONE, CAUSE_NONE, 6'h20, 1'b1}}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    bdca_tick_if tick_if();
    bdca_res_if  res_if();

    button_debounce_combo_autorepeat i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    t_cfg        cfg_now;
    logic [5:0]  btn_raw;
    logic [5:0]  btn_held;
    logic [5:0]  btn_used;
    logic [31:0] t_change [NBTN];
    logic [31:0] t_press  [NBTN];
    logic [31:0] t_repeat [NBTN];

    t_res action_exp_q [$];
    t_res want;

    int          err_cnt = 0;
    int          ticks_sent = 0;
    int          beats_checked = 0;
    int          cfg_loads = 0;
    int          cycle_cnt = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_go = 1'b0;
    logic [31:0] sim_ms;
    logic [5:0]  btn_goal;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic logic [2:0] btn_action(input int b);
        case (b)
            BTN_B1:  return ACT_B1;
            BTN_B2:  return ACT_B2;
            BTN_B4:  return ACT_B4;
            BTN_B5:  return ACT_B5;
            default: return ACT_NONE;
        endcase
    endfunction

    function automatic logic [15:0] cfg_field(input int idx);
        case (idx)
            REG_DEBOUNCE:     return cfg_now.debounce_ms;
            REG_FACE_DELAY:   return cfg_now.face_delay;
            REG_FACE_PERIOD:  return cfg_now.face_period;
            REG_LEVEL_DELAY:  return cfg_now.level_delay;
            REG_LEVEL_PERIOD: return cfg_now.level_period;
            default:          return '0;
        endcase
    endfunction

    task automatic cfg_set(input int idx, input logic [15:0] val);
        case (idx)
            REG_DEBOUNCE:     cfg_now.debounce_ms = val;
            REG_FACE_DELAY:   cfg_now.face_delay = val;
            REG_FACE_PERIOD:  cfg_now.face_period = val;
            REG_LEVEL_DELAY:  cfg_now.level_delay = val;
            REG_LEVEL_PERIOD: cfg_now.level_period = val;
            default: ;
        endcase
    endtask

    // debounce walk, then repeat walk; queues the beats one tick produces when keep is set
    task automatic debounce_tick(input logic [31:0] now, input logic [5:0] raw, input bit keep);
        t_res        tick_res [$];
        t_res        beat;
        logic [31:0] age;
        logic [15:0] hold_need;
        logic [15:0] gap_need;
        bit          face;
        bit          lvl;
        for (int b = 0; b < NBTN; b++) begin
            if (raw[b] != btn_raw[b]) begin
                btn_raw[b] = raw[b];
                t_change[b] = now;
            end
            age = now - t_change[b];
            if (age >= {16'h0, cfg_now.debounce_ms} && raw[b] != btn_held[b]) begin
                beat = '0;
                if (raw[b]) begin
                    btn_held[b] = 1'b1;
                    t_press[b] = now;
                    t_repeat[b] = now;
                    btn_used[b] = 1'b0;
                    if ((b == BTN_B1 || b == BTN_B2) && btn_held[BTN_B3]) begin
                        btn_used[b] = 1'b1;
                        btn_used[BTN_B3] = 1'b1;
                        beat.action = (b == BTN_B1) ? ACT_COMBO1 : ACT_COMBO2;
                        beat.cause = CAUSE_COMBO;
                        tick_res.push_back(beat);
                    end else if (btn_action(b) != ACT_NONE) begin
                        beat.action = btn_action(b);
                        beat.cause = CAUSE_PRESS;
                        tick_res.push_back(beat);
                    end
                end else begin
                    btn_held[b] = 1'b0;
                    if (b == BTN_B3 && !btn_used[b]) begin
                        beat.action = ACT_MODE;
                        beat.cause = CAUSE_RELEASE;
                        tick_res.push_back(beat);
                    end
                    btn_used[b] = 1'b0;
                end
            end
        end
        for (int b = 0; b < NBTN; b++) begin
            face = (b == BTN_B1 || b == BTN_B2);
            lvl = (b == BTN_B4 || b == BTN_B5);
            hold_need = face ? cfg_now.face_delay : cfg_now.level_delay;
            gap_need = face ? cfg_now.face_period : cfg_now.level_period;
            if (btn_held[b] && !btn_used[b] && (face || lvl) && !(face && btn_held[BTN_B3])
                    && (now - t_press[b]) >= {16'h0, hold_need}
                    && (now - t_repeat[b]) >= {16'h0, gap_need}) begin
                t_repeat[b] = now;
                beat = '0;
                beat.action = btn_action(b);
                beat.cause = CAUSE_REPEAT;
                tick_res.push_back(beat);
            end
        end
        if (tick_res.size() == 0) begin
            beat = '0;
            beat.action = ACT_NONE;
            beat.cause = CAUSE_NONE;
            tick_res.push_back(beat);
        end
        if (keep) begin
            foreach (tick_res[k]) begin
                tick_res[k].held_mask = btn_held;
                tick_res[k].last_of_tick = (k == tick_res.size() - 1);
                action_exp_q.push_back(tick_res[k]);
            end
        end
    endtask

    task automatic send_tick(input logic [31:0] now, input logic [5:0] raw, input bit keep);
        while ($urandom_range(99) < idle_pct) begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.now_ms <= now;
        tick_if.raw_levels <= raw;
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
        ticks_sent++;
        debounce_tick(now, raw, keep);
    endtask

    task automatic settle();
        tick_if.valid <= 1'b0;
        while (action_exp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input int idx, input bit wr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_BITS'(idx * REG_STRIDE);
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (wr) begin
            cfg_set(idx, data[15:0]);
        end else if (prdata !== {16'h0, cfg_field(idx)}) begin
            report_mismatch($sformatf("reg %0d read %0h expected %0h", idx, prdata,
                                      cfg_field(idx)));
        end
    endtask

    // upper data bits are junk on purpose; a write past the last register must be dropped
    task automatic load_cfg(input logic [15:0] deb, input logic [15:0] fdly,
                            input logic [15:0] fper, input logic [15:0] ldly,
                            input logic [15:0] lper);
        apb_xfer(REG_DEBOUNCE, 1'b1, {16'($urandom), deb});
        apb_xfer(REG_FACE_DELAY, 1'b1, {16'($urandom), fdly});
        apb_xfer(REG_FACE_PERIOD, 1'b1, {16'($urandom), fper});
        apb_xfer(REG_LEVEL_DELAY, 1'b1, {16'($urandom), ldly});
        apb_xfer(REG_LEVEL_PERIOD, 1'b1, {16'($urandom), lper});
        apb_xfer($urandom_range(NREG, MAX_REG), 1'b1, $urandom);
        for (int r = 0; r < NREG; r++) apb_xfer(r, 1'b0, '0);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        cfg_loads++;
    endtask

    // mostly held levels with bounce, some raw noise and time jumps
    task automatic run_random(input int n_ticks, input int step_max);
        logic [5:0] raw;
        int         b;
        for (int k = 0; k < n_ticks; k++) begin
            if ($urandom_range(99) < 8) begin
                b = $urandom_range(NBTN - 1);
                btn_goal[b] = ~btn_goal[b];
            end
            raw = btn_goal;
            if ($urandom_range(99) < 8) begin
                b = $urandom_range(NBTN - 1);
                raw[b] = ~raw[b];
            end
            if ($urandom_range(99) < 2) raw = 6'($urandom);
            if ($urandom_range(99) < 3) sim_ms = $urandom;
            else sim_ms = sim_ms + $urandom_range(step_max);
            send_tick(sim_ms, raw, 1'b1);
        end
    endtask

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (action_exp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat action %0d cause %0d held %0h",
                                          res_if.action, res_if.cause, res_if.held_mask));
            end else begin
                want = action_exp_q.pop_front();
                beats_checked++;
                if (res_if.action !== want.action)
                    report_mismatch($sformatf("action %0d expected %0d", res_if.action,
                                              want.action));
                if (res_if.cause !== want.cause)
                    report_mismatch($sformatf("cause %0d expected %0d", res_if.cause,
                                              want.cause));
                if (res_if.held_mask !== want.held_mask)
                    report_mismatch($sformatf("held_mask %0h expected %0h",
                                              res_if.held_mask, want.held_mask));
                if (res_if.last_of_tick !== want.last_of_tick)
                    report_mismatch($sformatf("last_of_tick %0b expected %0b",
                                              res_if.last_of_tick, want.last_of_tick));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout with %0d beats outstanding", action_exp_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        tick_if.valid <= 1'b0;
        tick_if.now_ms <= '0;
        tick_if.raw_levels <= '0;
        cfg_now = '{RST_DEBOUNCE, RST_FACE_DELAY, RST_FACE_PERIOD, RST_LEVEL_DELAY,
                    RST_LEVEL_PERIOD};
        btn_raw = '0;
        btn_held = '0;
        btn_used = '0;
        for (int b = 0; b < NBTN; b++) begin
            t_change[b] = '0;
            t_press[b] = '0;
            t_repeat[b] = '0;
        end
        btn_goal = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_TBL[r].cfg_zero) begin
                settle();
                load_cfg('0, '0, '0, '0, '0);
            end
            send_tick(DIR_TBL[r].now_ms, DIR_TBL[r].raw, !DIR_TBL[r].typed);
            if (DIR_TBL[r].typed) action_exp_q.push_back(DIR_TBL[r].exp_res);
        end

        sim_ms = 32'hFFFF_FFA0;
        settle();
        load_cfg(16'd3, 16'd25, 16'd6, 16'd15, 16'd4);
        run_random(83, 3);

        settle();
        idle_pct = 56;
        load_cfg(16'd1, 16'd12, 16'd1, 16'd9, 16'd2);
        run_random(83, 2);

        settle();
        idle_pct = 0;
        stall_pct = 56;
        load_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(83, 40000);

        settle();
        idle_pct = 21;
        stall_pct = 21;
        load_cfg(16'($urandom_range(6)), 16'($urandom_range(30)), 16'($urandom_range(8)),
                 16'($urandom_range(30)), 16'($urandom_range(8)));
        hold_go = 1'b1;
        run_random(83, 5);

        settle();
        $display("covered %0d ticks over %0d settings loads and four handshake mixes",
                 ticks_sent, cfg_loads);
        $display("%0d result beats checked, %0d mismatches", beats_checked, err_cnt);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
